/* hdl/wpp_pkg.sv */
// Shared types and constants for the mono PCM WAV stream parser.
// Used by wpp_front, wpp_queue, wpp_back and the top level.
// Holds no logic of its own.
package wpp_pkg;

  // Result kinds as they appear on the kind port.
  localparam logic [1:0] KIND_HDR    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERR    = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_RIFF     = 3'd0;
  localparam logic [2:0] ERR_WAVE     = 3'd1;
  localparam logic [2:0] ERR_FMT_TAG  = 3'd2;
  localparam logic [2:0] ERR_FMT_SIZE = 3'd3;
  localparam logic [2:0] ERR_FORMAT   = 3'd4;
  localparam logic [2:0] ERR_CHANNELS = 3'd5;
  localparam logic [2:0] ERR_DATA_TAG = 3'd6;
  localparam logic [2:0] ERR_DEPTH    = 3'd7;

  // Header tags, byte order as in the file.
  localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [7:0] TAG_FMT  [4] = '{8'h66, 8'h6D, 8'h74, 8'h20};
  localparam logic [7:0] TAG_DATA [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

  // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT for every 32-bit x.
  localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;
  localparam int          DIV3_SHIFT = 33;

  // Token queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    TOK_HDR,
    TOK_SAMPLE,
    TOK_ERR
  } tok_kind_t;

  // One classified transaction from the front to the back.
  typedef struct packed {
    tok_kind_t   kind;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [7:0]  depth;
    logic [31:0] word;   // data size on a header token, sample on a sample token
  } tok_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic valid;
    tok_t tok;
  } q_head_t;

endpackage

/* hdl/wpp_front.sv */
// Front part of the WAV parser: takes one byte per transaction, checks the
// header, captures its fields and assembles samples into tokens.
// Depends on wpp_pkg.
module wpp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    data_byte,
  input  logic          first,
  output logic          tok_push,
  output wpp_pkg::tok_t tok
);

  typedef struct packed {
    logic       chk;
    logic [7:0] expect_byte;
    logic [2:0] code;
  } hdr_rule_t;

  // Fixed-value bytes of the header and the error each one raises.
  function automatic hdr_rule_t hdr_rule(input logic [5:0] pos);
    hdr_rule_t r;
    r.chk         = 1'b1;
    r.expect_byte = 8'd0;
    r.code        = wpp_pkg::ERR_RIFF;
    case (pos) inside
      [6'd0:6'd3]: begin
        r.expect_byte = wpp_pkg::TAG_RIFF[pos[1:0]];
      end
      [6'd8:6'd11]: begin
        r.expect_byte = wpp_pkg::TAG_WAVE[pos[1:0]];
        r.code        = wpp_pkg::ERR_WAVE;
      end
      [6'd12:6'd15]: begin
        r.expect_byte = wpp_pkg::TAG_FMT[pos[1:0]];
        r.code        = wpp_pkg::ERR_FMT_TAG;
      end
      [6'd16:6'd19]: begin
        r.expect_byte = (pos == 6'd16) ? 8'd16 : 8'd0;
        r.code        = wpp_pkg::ERR_FMT_SIZE;
      end
      [6'd20:6'd21]: begin
        r.expect_byte = (pos == 6'd20) ? 8'd1 : 8'd0;
        r.code        = wpp_pkg::ERR_FORMAT;
      end
      [6'd22:6'd23]: begin
        r.expect_byte = (pos == 6'd22) ? 8'd1 : 8'd0;
        r.code        = wpp_pkg::ERR_CHANNELS;
      end
      [6'd36:6'd39]: begin
        r.expect_byte = wpp_pkg::TAG_DATA[pos[1:0]];
        r.code        = wpp_pkg::ERR_DATA_TAG;
      end
      default: begin
        r.chk = 1'b0;
      end
    endcase
    return r;
  endfunction

  wpp_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      pos_r, pos_nxt;
  logic [31:0]     rate_r, rate_nxt;
  logic [7:0]      depth_r, depth_nxt;
  logic [31:0]     size_r, size_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [1:0]      bis_r, bis_nxt;

  wpp_pkg::phase_t cur_phase;
  logic [5:0]      cur_pos;
  hdr_rule_t       rule;
  logic [31:0]     size_new;
  logic [31:0]     shift_new;
  logic [1:0]      bis_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wpp_pkg::PH_IDLE;
      pos_r   <= '0;
      bis_r   <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      bis_r   <= bis_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r  <= rate_nxt;
    depth_r <= depth_nxt;
    size_r  <= size_nxt;
  end

  always_comb begin
    cur_phase = first ? wpp_pkg::PH_HEAD : phase_r;
    cur_pos   = first ? 6'd0 : pos_r;
    rule      = hdr_rule(cur_pos);
    size_new  = {data_byte, size_r[31:8]};
    shift_new = {data_byte, shift_r[31:8]};
    bis_new   = bis_r + 2'd1;

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rate_nxt  = rate_r;
    depth_nxt = depth_r;
    size_nxt  = size_r;
    shift_nxt = shift_r;
    bis_nxt   = bis_r;

    tok_push   = 1'b0;
    tok.kind   = wpp_pkg::TOK_ERR;
    tok.code   = rule.code;
    tok.rate   = rate_r;
    tok.depth  = depth_r;
    tok.word   = size_new;

    if (byte_valid) begin
      unique case (cur_phase)
        wpp_pkg::PH_HEAD: begin
          phase_nxt = wpp_pkg::PH_HEAD;
          pos_nxt   = cur_pos + 6'd1;
          if (rule.chk) begin
            if (data_byte != rule.expect_byte) begin
              tok_push  = 1'b1;
              phase_nxt = wpp_pkg::PH_IDLE;
            end
          end else if (cur_pos >= 6'd24 && cur_pos <= 6'd27) begin
            rate_nxt = {data_byte, rate_r[31:8]};
          end else if (cur_pos == 6'd34) begin
            depth_nxt = data_byte;
            if (data_byte != 8'd8 && data_byte != 8'd16 &&
                data_byte != 8'd24 && data_byte != 8'd32) begin
              tok_push  = 1'b1;
              tok.code  = wpp_pkg::ERR_DEPTH;
              phase_nxt = wpp_pkg::PH_IDLE;
            end
          end else if (cur_pos >= 6'd40) begin
            size_nxt = size_new;
            if (cur_pos == 6'd43) begin
              tok_push  = 1'b1;
              tok.kind  = wpp_pkg::TOK_HDR;
              phase_nxt = wpp_pkg::PH_DATA;
              shift_nxt = '0;
              bis_nxt   = '0;
            end
          end
        end
        wpp_pkg::PH_DATA: begin
          shift_nxt = shift_new;
          bis_nxt   = bis_new;
          if (bis_new == depth_r[4:3]) begin
            tok_push  = 1'b1;
            tok.kind  = wpp_pkg::TOK_SAMPLE;
            tok.word  = shift_new;
            shift_nxt = '0;
            bis_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/wpp_queue.sv */
// Short token queue that decouples the parser front from the result back.
// Depends on wpp_pkg.
module wpp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wpp_pkg::tok_t    push_tok,
  output logic             full,
  input  logic             pop,
  output wpp_pkg::q_head_t head
);

  wpp_pkg::tok_t                mem_r [wpp_pkg::QUEUE_DEPTH];
  logic [wpp_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wpp_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wpp_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count_r == (wpp_pkg::QUEUE_AW+1)'(wpp_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.tok   = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head.valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* hdl/wpp_back.sv */
// Back part of the WAV parser: works out the sample count, tracks the
// samples left and holds the result register. Depends on wpp_pkg.
module wpp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wpp_pkg::q_head_t    head,
  output logic                tok_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_kind,
  output logic [2:0]          out_error_code,
  output logic [31:0]         out_sample_rate,
  output logic [7:0]          out_bits,
  output logic [31:0]         out_sample_count,
  output logic signed [31:0]  out_sample,
  output logic                out_last
);

  wpp_pkg::bk_state_t state_r, state_nxt;
  logic               active_r, active_nxt;
  logic [31:0]        left_r, left_nxt;
  logic               valid_r, valid_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [31:0]        rate_r, rate_nxt;
  logic [7:0]         depth_r, depth_nxt;
  logic [63:0]        prod_r, prod_nxt;

  logic [1:0]         kind_r, kind_nxt;
  logic [2:0]         code_r, code_nxt;
  logic [31:0]        orate_r, orate_nxt;
  logic [7:0]         obits_r, obits_nxt;
  logic [31:0]        ocount_r, ocount_nxt;
  logic [31:0]        osample_r, osample_nxt;
  logic               olast_r, olast_nxt;

  logic               out_free;
  logic [31:0]        count;
  logic [31:0]        left_dec;

  assign out_empty        = !valid_r;
  assign out_kind         = kind_r;
  assign out_error_code   = code_r;
  assign out_sample_rate  = orate_r;
  assign out_bits         = obits_r;
  assign out_sample_count = ocount_r;
  assign out_sample       = osample_r;
  assign out_last         = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wpp_pkg::BK_RUN;
      active_r <= 1'b0;
      left_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      left_r   <= left_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    rate_r    <= rate_nxt;
    depth_r   <= depth_nxt;
    prod_r    <= prod_nxt;
    kind_r    <= kind_nxt;
    code_r    <= code_nxt;
    orate_r   <= orate_nxt;
    obits_r   <= obits_nxt;
    ocount_r  <= ocount_nxt;
    osample_r <= osample_nxt;
    olast_r   <= olast_nxt;
  end

  // Sample count from the data size: depth is already known to be legal.
  always_comb begin
    unique case (depth_r)
      8'd8:    count = size_r;
      8'd16:   count = {1'b0, size_r[31:1]};
      8'd24:   count = 32'(prod_r[63:wpp_pkg::DIV3_SHIFT]);
      default: count = {2'b00, size_r[31:2]};
    endcase
  end

  always_comb begin
    out_free    = !valid_r || out_pop;
    left_dec    = left_r - 32'd1;

    state_nxt   = state_r;
    active_nxt  = active_r;
    left_nxt    = left_r;
    valid_nxt   = valid_r && !out_pop;
    size_nxt    = size_r;
    rate_nxt    = rate_r;
    depth_nxt   = depth_r;
    prod_nxt    = prod_r;
    kind_nxt    = kind_r;
    code_nxt    = code_r;
    orate_nxt   = orate_r;
    obits_nxt   = obits_r;
    ocount_nxt  = ocount_r;
    osample_nxt = osample_r;
    olast_nxt   = olast_r;
    tok_pop     = 1'b0;

    unique case (state_r)
      wpp_pkg::BK_RUN: begin
        if (head.valid) begin
          unique case (head.tok.kind)
            wpp_pkg::TOK_HDR: begin
              tok_pop   = 1'b1;
              size_nxt  = head.tok.word;
              rate_nxt  = head.tok.rate;
              depth_nxt = head.tok.depth;
              state_nxt = wpp_pkg::BK_MUL;
            end
            wpp_pkg::TOK_ERR: begin
              if (out_free) begin
                tok_pop     = 1'b1;
                active_nxt  = 1'b0;
                valid_nxt   = 1'b1;
                kind_nxt    = wpp_pkg::KIND_ERR;
                code_nxt    = head.tok.code;
                orate_nxt   = '0;
                obits_nxt   = '0;
                ocount_nxt  = '0;
                osample_nxt = '0;
                olast_nxt   = 1'b1;
              end
            end
            default: begin
              if (!active_r) begin
                tok_pop = 1'b1;
              end else if (out_free) begin
                tok_pop     = 1'b1;
                left_nxt    = left_dec;
                active_nxt  = (left_dec != '0);
                valid_nxt   = 1'b1;
                kind_nxt    = wpp_pkg::KIND_SAMPLE;
                code_nxt    = '0;
                orate_nxt   = '0;
                obits_nxt   = '0;
                ocount_nxt  = '0;
                osample_nxt = head.tok.word;
                olast_nxt   = (left_dec == '0);
              end
            end
          endcase
        end
      end
      wpp_pkg::BK_MUL: begin
        prod_nxt  = size_r * wpp_pkg::DIV3_RECIP;
        state_nxt = wpp_pkg::BK_EMIT;
      end
      default: begin
        if (out_free) begin
          left_nxt    = count;
          active_nxt  = (count != '0);
          valid_nxt   = 1'b1;
          kind_nxt    = wpp_pkg::KIND_HDR;
          code_nxt    = '0;
          orate_nxt   = rate_r;
          obits_nxt   = depth_r;
          ocount_nxt  = count;
          osample_nxt = '0;
          olast_nxt   = (count == '0);
          state_nxt   = wpp_pkg::BK_RUN;
        end
      end
    endcase
  end

endmodule

/* hdl/wav_pcm_mono_stream_parser.sv */
// Mono PCM WAV stream parser, top level: wpp_front -> wpp_queue -> wpp_back.
// A sample or error token goes through the token queue into the back's output register;
// a header token also passes the back's multiply and emit states on the way.
// Throughput: one byte per cycle while the queue has room; the header's extra back-end
// states (the multiply for three-byte samples) are soaked up by the four-entry token queue.
// Reset (rst_n low, synchronous) empties the queue and output and idles the parser.
module wav_pcm_mono_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_error_code,
  output logic [31:0]        out_sample_rate,
  output logic [7:0]         out_bits,
  output logic [31:0]        out_sample_count,
  output logic signed [31:0] out_sample,
  output logic               out_last
);

  // The front classifies every accepted byte: header bytes are checked
  // against the fixed layout and fields are captured, while data bytes are
  // assembled into left-aligned samples. Each byte that completes something
  // yields one token transaction into the queue.
  wpp_pkg::tok_t    tok;
  logic             tok_push;
  logic             tok_pop;
  wpp_pkg::q_head_t head;
  logic             byte_accept;

  // A byte is taken whenever the queue has room, so full simply mirrors it.
  assign byte_accept = push && !full;

  wpp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_accept),
    .data_byte  (in_data_byte),
    .first      (in_first),
    .tok_push   (tok_push),
    .tok        (tok)
  );

  wpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (tok),
    .full     (full),
    .pop      (tok_pop),
    .head     (head)
  );

  // The back turns tokens into results. It divides the data size by the
  // bytes per sample, counts samples down so that the final one carries
  // last, and drops sample tokens once the count is spent or after an error.
  // A result loads as the waiting one pops; header tokens are taken while one waits.
  wpp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .tok_pop          (tok_pop),
    .out_empty        (empty),
    .out_pop          (pop),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_sample_rate  (out_sample_rate),
    .out_bits         (out_bits),
    .out_sample_count (out_sample_count),
    .out_sample       (out_sample),
    .out_last         (out_last)
  );

endmodule

/* test/wav_parse_checker.sv */
`timescale 1ns / 100ps
// Checker for the mono PCM WAV stream parser: watches both queue ports,
// predicts every result from the accepted bytes and compares in order.
// Depends on wpp_pkg for result kinds, error codes, tags and the phase type.
module wav_parse_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         out_kind,
  input  logic [2:0]         out_error_code,
  input  logic [31:0]        out_sample_rate,
  input  logic [7:0]         out_bits,
  input  logic [31:0]        out_sample_count,
  input  logic signed [31:0] out_sample,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [7:0]  bits;
    logic [31:0] count;
    logic [31:0] sample;
    logic        last;
  } wav_result_t;

  wav_result_t expected_results[$];
  int          mismatches = 0;

  // Predicted parser state.
  wpp_pkg::phase_t phase;
  logic [5:0]      hdr_pos;
  logic [31:0]     rate_acc;
  logic [7:0]      depth;
  logic [31:0]     size_acc;
  logic [31:0]     samples_left;
  logic [31:0]     sample_acc;
  logic [1:0]      byte_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_state();
    phase        = wpp_pkg::PH_IDLE;
    hdr_pos      = '0;
    rate_acc     = '0;
    depth        = '0;
    size_acc     = '0;
    samples_left = '0;
    sample_acc   = '0;
    byte_idx     = '0;
  endtask

  // Advances the predicted state by one byte and queues any result it causes.
  task automatic parse_byte(input logic first, input logic [7:0] b);
    wav_result_t r;
    logic        emit;
    logic        bad;
    logic [2:0]  code;
    logic [5:0]  p;
    logic [31:0] per_sample;
    r    = '0;
    emit = 1'b0;
    bad  = 1'b0;
    code = wpp_pkg::ERR_RIFF;
    if (first) begin
      clear_state();
      phase = wpp_pkg::PH_HEAD;
    end
    if (phase == wpp_pkg::PH_HEAD) begin
      p       = hdr_pos;
      hdr_pos = hdr_pos + 6'd1;
      if (p < 4) begin
        bad  = (b != wpp_pkg::TAG_RIFF[p[1:0]]);
        code = wpp_pkg::ERR_RIFF;
      end else if (p < 8) begin
        // RIFF chunk size is not checked
      end else if (p < 12) begin
        bad  = (b != wpp_pkg::TAG_WAVE[p[1:0]]);
        code = wpp_pkg::ERR_WAVE;
      end else if (p < 16) begin
        bad  = (b != wpp_pkg::TAG_FMT[p[1:0]]);
        code = wpp_pkg::ERR_FMT_TAG;
      end else if (p < 20) begin
        bad  = (b != ((p == 16) ? 8'd16 : 8'd0));
        code = wpp_pkg::ERR_FMT_SIZE;
      end else if (p < 22) begin
        bad  = (b != ((p == 20) ? 8'd1 : 8'd0));
        code = wpp_pkg::ERR_FORMAT;
      end else if (p < 24) begin
        bad  = (b != ((p == 22) ? 8'd1 : 8'd0));
        code = wpp_pkg::ERR_CHANNELS;
      end else if (p < 28) begin
        rate_acc = {b, rate_acc[31:8]};
      end else if (p < 34) begin
        // byte rate and block align are not checked
      end else if (p == 34) begin
        depth = b;
        bad   = !(b == 8'd8 || b == 8'd16 || b == 8'd24 || b == 8'd32);
        code  = wpp_pkg::ERR_DEPTH;
      end else if (p == 35) begin
        // high byte of the depth is not checked
      end else if (p < 40) begin
        bad  = (b != wpp_pkg::TAG_DATA[p[1:0]]);
        code = wpp_pkg::ERR_DATA_TAG;
      end else begin
        size_acc = {b, size_acc[31:8]};
        if (p == 43) begin
          per_sample = {29'd0, depth[5:3]};
          if (per_sample == 0) per_sample = 32'd1;
          samples_left = size_acc / per_sample;
          sample_acc   = '0;
          byte_idx     = '0;
          phase        = (samples_left == 0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_DATA;
          emit         = 1'b1;
          r.kind       = wpp_pkg::KIND_HDR;
          r.rate       = rate_acc;
          r.bits       = depth;
          r.count      = samples_left;
          r.last       = (samples_left == 0);
        end
      end
      if (bad) begin
        phase  = wpp_pkg::PH_IDLE;
        emit   = 1'b1;
        r.kind = wpp_pkg::KIND_ERR;
        r.code = code;
        r.last = 1'b1;
      end
    end else if (phase == wpp_pkg::PH_DATA) begin
      // Bytes enter at the top so that the sample ends up left-aligned.
      sample_acc = {b, sample_acc[31:8]};
      byte_idx   = byte_idx + 2'd1;
      if (byte_idx == depth[4:3]) begin
        byte_idx     = '0;
        samples_left = samples_left - 32'd1;
        if (samples_left == 0) phase = wpp_pkg::PH_IDLE;
        emit     = 1'b1;
        r.kind   = wpp_pkg::KIND_SAMPLE;
        r.sample = sample_acc;
        r.last   = (samples_left == 0);
        sample_acc = '0;
      end
    end
    if (emit) expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    wav_result_t seen;
    wav_result_t want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (push && !full) parse_byte(in_first, in_data_byte);
      if (pop && !empty) begin
        seen = '{out_kind, out_error_code, out_sample_rate, out_bits,
                 out_sample_count, out_sample, out_last};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: kind %0d code %0d sample %h",
                     $realtime, seen.kind, seen.code, seen.sample);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected kind %0d code %0d rate %h bits %0d count %h sample %h last %0d",
                       want.kind, want.code, want.rate, want.bits, want.count,
                       want.sample, want.last);
              $display("  actual   kind %0d code %0d rate %h bits %0d count %h sample %h last %0d",
                       seen.kind, seen.code, seen.rate, seen.bits, seen.count,
                       seen.sample, seen.last);
            end
          end
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

/* test/wav_pcm_mono_stream_parser_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the mono PCM WAV stream parser: makes the byte stimulus,
// drives the result side with stalls and gives the verdict.
// Depends on wpp_pkg, wav_pcm_mono_stream_parser and wav_parse_checker.
module wav_pcm_mono_stream_parser_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_first = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         out_kind;
  logic [2:0]         out_error_code;
  logic [31:0]        out_sample_rate;
  logic [7:0]         out_bits;
  logic [31:0]        out_sample_count;
  logic signed [31:0] out_sample;
  logic               out_last;

  int fail_count;
  int pending;

  // Transactions accepted on the byte side, counted at the clock edge so
  // that the receiver sees a settled value.
  int items_taken = 0;

  // Sender bookkeeping: bytes offered so far, what is left of the current
  // burst, and which cases the file generator has managed to hit.
  int       bytes_offered = 0;
  int       burst_left = 0;
  bit [7:0] err_seen = '0;
  bit [3:0] depth_seen = '0;
  bit       zero_seen = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wav_pcm_mono_stream_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_sample_rate  (out_sample_rate),
    .out_bits         (out_bits),
    .out_sample_count (out_sample_count),
    .out_sample       (out_sample),
    .out_last         (out_last)
  );

  // The checker sees exactly what the block sees and keeps its own account
  // of what should come out.
  wav_parse_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_sample_rate  (out_sample_rate),
    .out_bits         (out_bits),
    .out_sample_count (out_sample_count),
    .out_sample       (out_sample),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if (rst_n && push && !full) items_taken <= items_taken + 1;
  end

  // Offers one byte and returns once it has been taken. The sender works in
  // bursts; between bursts push may drop for a random gap. Within a burst
  // push stays high, so there is never a fall and rise in one time step.
  task automatic send_byte(input logic first, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push         <= 1'b1;
    in_first     <= first;
    in_data_byte <= b;
    @(posedge clk);
    // full read straight after the edge is still the value the edge saw.
    while (full) @(posedge clk);
    bytes_offered++;
  endtask

  // Data bytes lean towards the values that make extreme samples.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  // Builds one file with a well-formed header and random content, then
  // either spoils one checked header byte, cuts the header short, or sends
  // the data. Data may be cut short, or followed by a few stray bytes that
  // the parser should ignore. Files with a huge data size are abandoned
  // after a handful of bytes, so the next file restarts the parser mid-data.
  // Depths and errors not yet generated are picked first, and headers are
  // spoilt more often until every error has been seen.
  task automatic play_file();
    logic [7:0]  hdr [44];
    logic [31:0] rate;
    logic [31:0] size;
    logic [31:0] count;
    logic [7:0]  depth;
    logic [2:0]  code;
    int          depth_idx;
    int          per_sample;
    int          pos;
    int          n_bytes;
    int          i;
    bit          spoilt;
    bit          whole;
    depth_idx  = $urandom_range(0, 3);
    for (i = 3; i >= 0; i--) if (!depth_seen[i]) depth_idx = i;
    per_sample = depth_idx + 1;
    depth      = 8'(8 * per_sample);
    case ($urandom_range(0, 3))
      0:       rate = 32'd0;
      1:       rate = 32'hFFFF_FFFF;
      default: rate = $urandom();
    endcase
    case ($urandom_range(0, 9))
      0:       size = 32'd0;
      1:       size = 32'hFFFF_FFFF;
      2:       size = $urandom();
      default: size = $urandom_range(0, 24);
    endcase
    for (i = 0; i < 4; i++) begin
      hdr[i]      = wpp_pkg::TAG_RIFF[i];
      hdr[4 + i]  = 8'($urandom());
      hdr[8 + i]  = wpp_pkg::TAG_WAVE[i];
      hdr[12 + i] = wpp_pkg::TAG_FMT[i];
      hdr[24 + i] = rate[8 * i +: 8];
      hdr[36 + i] = wpp_pkg::TAG_DATA[i];
      hdr[40 + i] = size[8 * i +: 8];
    end
    hdr[16] = 8'd16;
    hdr[17] = 8'd0;
    hdr[18] = 8'd0;
    hdr[19] = 8'd0;
    hdr[20] = 8'd1;
    hdr[21] = 8'd0;
    hdr[22] = 8'd1;
    hdr[23] = 8'd0;
    for (i = 28; i < 34; i++) hdr[i] = 8'($urandom());
    hdr[34] = depth;
    hdr[35] = 8'($urandom());
    count   = size / per_sample;

    spoilt = ($urandom_range(0, 9) < ((&err_seen) ? 4 : 6));
    whole  = 1'b0;
    if (spoilt) begin
      code = 3'($urandom_range(0, 7));
      for (i = 7; i >= 0; i--) if (!err_seen[i]) code = 3'(i);
      pos  = 34;
      case (code)
        wpp_pkg::ERR_RIFF:     pos = $urandom_range(0, 3);
        wpp_pkg::ERR_WAVE:     pos = $urandom_range(8, 11);
        wpp_pkg::ERR_FMT_TAG:  pos = $urandom_range(12, 15);
        wpp_pkg::ERR_FMT_SIZE: pos = $urandom_range(16, 19);
        wpp_pkg::ERR_FORMAT:   pos = $urandom_range(20, 21);
        wpp_pkg::ERR_CHANNELS: pos = $urandom_range(22, 23);
        wpp_pkg::ERR_DATA_TAG: pos = $urandom_range(36, 39);
        default:               pos = 34;
      endcase
      if (code == wpp_pkg::ERR_DEPTH) begin
        do hdr[34] = 8'($urandom());
        while (hdr[34] == 8'd8 || hdr[34] == 8'd16 || hdr[34] == 8'd24 ||
               hdr[34] == 8'd32);
      end else begin
        hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
      end
      err_seen[code] = 1'b1;
      n_bytes = pos + 1;
    end else if ($urandom_range(0, 9) == 0) begin
      n_bytes = $urandom_range(1, 43);
    end else begin
      n_bytes = 44;
      whole   = 1'b1;
      depth_seen[depth_idx] = 1'b1;
      if (count == 0) zero_seen = 1'b1;
    end

    for (i = 0; i < n_bytes; i++) send_byte(i == 0, hdr[i]);

    if (!whole)
      n_bytes = $urandom_range(0, 3);
    else if (count > 64)
      n_bytes = $urandom_range(0, 16);
    else if ($urandom_range(0, 6) == 0)
      n_bytes = $urandom_range(0, count * per_sample);
    else
      n_bytes = count * per_sample + $urandom_range(0, 3);
    for (i = 0; i < n_bytes; i++) send_byte(1'b0, pick_byte());
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int n_files;
    n_files = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: bytes while idle are dropped, a bad first byte gives
    // a RIFF error, and a first mark part-way through a header restarts it.
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h52);
    send_byte(1'b1, wpp_pkg::TAG_RIFF[0]);
    send_byte(1'b0, wpp_pkg::TAG_RIFF[1]);
    send_byte(1'b1, wpp_pkg::TAG_RIFF[0]);
    send_byte(1'b0, wpp_pkg::TAG_RIFF[1]);
    send_byte(1'b0, wpp_pkg::TAG_RIFF[2]);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h46);

    // Random files until enough bytes have gone in and every error, every
    // depth and an empty data chunk have been generated, with a cap.
    while ((bytes_offered < 600 || !(&err_seen) || !(&depth_seen) || !zero_seen)
           && n_files < 400) begin
      play_file();
      n_files++;
    end
    push <= 1'b0;

    // Let the checker's count of outstanding results settle, drain it, then
    // allow for the header latency and any stray output.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: switches among several stall patterns. Once, after a good
  // number of transactions, it holds off for a long stretch while the sender
  // keeps offering, so the token queue fills and full is seen.
  initial begin : receiver
    int cycle;
    int mode;
    int hold;
    bit held;
    cycle = 0;
    mode  = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 50 == 0) mode = $urandom_range(0, 4);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!held && items_taken >= 200) begin
        held = 1'b1;
        hold = 300;
        pop <= 1'b0;
      end else begin
        case (mode)
          0, 1:    pop <= 1'b1;
          2:       pop <= ($urandom_range(0, 1) == 0);
          3:       pop <= (cycle % 4 == 0);
          default: pop <= (cycle % 50 >= 40);
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
